@@ hw/rtl/glyph_stroke_decoder_core_defines.svh @@
// Assertion macros used by the glyph stroke decoder controller.
`ifndef GLYPH_STROKE_DECODER_CORE_DEFINES_SVH
`define GLYPH_STROKE_DECODER_CORE_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define GSD_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gsd: same-cycle check failed");

// Check that holds in the cycle after its trigger.
`define GSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gsd: next-cycle check failed");

`endif

@@ hw/rtl/gsd_pkg.sv @@
// Shared types and constants of the glyph stroke decoder.
`timescale 1ns / 1ps

package gsd_pkg;

    localparam logic [1:0] CMD_WRITE_ENTRY = 2'd0;
    localparam logic [1:0] CMD_WRITE_BYTE  = 2'd1;
    localparam logic [1:0] CMD_SELECT      = 2'd2;
    localparam logic [1:0] CMD_NEXT        = 2'd3;

    localparam logic [2:0] ST_ACK      = 3'd0;
    localparam logic [2:0] ST_DRAW     = 3'd1;
    localparam logic [2:0] ST_MOVE     = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_BADCUR   = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    localparam logic [7:0] BYTE_MOVE = 8'hCE;
    localparam logic [7:0] BYTE_END  = 8'h63;

    localparam int          CURSOR_W       = 18;
    localparam logic [17:0] CURSOR_INVALID = 18'h3FFFF;

    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 18;
    localparam logic [0:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [0:0] CFG_DATA_SIZE   = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic [11:0]       entry_slot;
        logic [15:0]       glyph_number;
        logic [16:0]       glyph_offset;
        logic [16:0]       data_address;
        logic signed [7:0] data_byte;
    } gsd_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [7:0] point_x;
        logic signed [7:0] point_y;
        logic [16:0]       cursor;
    } gsd_out_t;

    typedef struct packed {
        logic take;
        logic srch_probe;
        logic srch_miss;
        logic srch_step;
        logic pt_start;
        logic pt_eval;
        logic pt_y;
        logic out_load;
    } gsd_ctl_t;

    typedef struct packed {
        logic srch_open;
        logic srch_hit;
        logic pt_cur_bad;
        logic pt_move_first;
        logic pt_next_bad;
        logic pt_is_end;
    } gsd_sts_t;

endpackage

@@ hw/rtl/gsd_controller.sv @@
// Command sequencer of the glyph stroke decoder.
`timescale 1ns / 1ps
`include "glyph_stroke_decoder_core_defines.svh"

module gsd_controller (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_command,
    output logic             m_valid,
    input  logic             m_ready,
    input  gsd_pkg::gsd_sts_t sts,
    output gsd_pkg::gsd_ctl_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_SRCH_ISSUE = 7'b0000010,
        S_SRCH_EVAL  = 7'b0000100,
        S_PT_START   = 7'b0001000,
        S_PT_EVAL    = 7'b0010000,
        S_PT_Y       = 7'b0100000,
        S_EMIT       = 7'b1000000
    } gsd_state_t;

    gsd_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.take = 1'b1;
                    unique case (s_command)
                        gsd_pkg::CMD_SELECT: state_next = S_SRCH_ISSUE;
                        gsd_pkg::CMD_NEXT:   state_next = S_PT_START;
                        default:             state_next = S_EMIT;
                    endcase
                end
            end
            S_SRCH_ISSUE: begin
                if (sts.srch_open) begin
                    ctl.srch_probe = 1'b1;
                    state_next     = S_SRCH_EVAL;
                end else begin
                    ctl.srch_miss = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_SRCH_EVAL: begin
                ctl.srch_step = 1'b1;
                state_next    = sts.srch_hit ? S_EMIT : S_SRCH_ISSUE;
            end
            S_PT_START: begin
                ctl.pt_start = 1'b1;
                state_next   = sts.pt_cur_bad ? S_EMIT : S_PT_EVAL;
            end
            S_PT_EVAL: begin
                ctl.pt_eval = 1'b1;
                if (sts.pt_move_first) begin
                    state_next = sts.pt_next_bad ? S_EMIT : S_PT_EVAL;
                end else if (sts.pt_is_end || sts.pt_next_bad) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_PT_Y;
                end
            end
            S_PT_Y: begin
                ctl.pt_y   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `GSD_ASSERT_SAME(a_load_into_free_slot, aclk, aresetn, ctl.out_load, out_free)
    `GSD_ASSERT_SAME(a_result_after_emit, aclk, aresetn, $rose(out_valid_reg), $past(state_reg == S_EMIT))
    `GSD_ASSERT_NEXT(a_next_enters_point, aclk, aresetn, s_valid && s_ready && (s_command == gsd_pkg::CMD_NEXT), state_reg == S_PT_START)
    `GSD_ASSERT_NEXT(a_search_loops, aclk, aresetn, (state_reg == S_SRCH_EVAL) && !sts.srch_hit, state_reg == S_SRCH_ISSUE)

endmodule

@@ hw/rtl/gsd_datapath.sv @@
// Tables, stroke store, cursor and result register of the glyph stroke decoder.
`timescale 1ns / 1ps

module gsd_datapath #(
    parameter int MAX_GLYPHS = 4096,
    parameter int DATA_DEPTH = 131072
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  gsd_pkg::gsd_in_t                  s_data,
    input  logic                              cfg_we,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  gsd_pkg::gsd_ctl_t                 ctl,
    output gsd_pkg::gsd_sts_t                 sts,
    output gsd_pkg::gsd_out_t                 m_data
);

    localparam int GW = $clog2(MAX_GLYPHS);
    localparam int EW = (GW + 1 > 13) ? GW + 1 : 13;
    localparam int AW = $clog2(DATA_DEPTH);
    localparam int LW = $clog2(DATA_DEPTH + 1);
    localparam int PW = (LW > 19) ? LW : 19;

    logic [32:0] table_mem [MAX_GLYPHS];
    logic [32:0] table_rd_reg;
    logic [7:0]  store_mem [DATA_DEPTH];
    logic [7:0]  store_rd_reg;

    logic [12:0]                  entry_count_reg;
    logic [17:0]                  data_size_reg;
    logic [gsd_pkg::CURSOR_W-1:0] cursor_reg, cursor_next;

    logic [EW-1:0]     lo_reg, hi_reg, mid_reg;
    logic [15:0]       key_reg;
    logic [PW-1:0]     ptr_reg;
    logic              moved_reg;
    logic [7:0]        byte_x_reg;
    logic [2:0]        res_status_reg;
    logic signed [7:0] res_x_reg, res_y_reg;
    gsd_pkg::gsd_out_t out_reg;

    logic [EW-1:0] slot_ext, count_ext, valid_entries, mid;
    logic          slot_ok;
    logic [PW-1:0] addr_ext, size_ext, lim, cur_ext, ptr_inc, ptr_inc2, store_raddr;
    logic          addr_ok;
    logic          wr_entry, wr_byte;

    assign slot_ext      = EW'(s_data.entry_slot);
    assign slot_ok       = slot_ext < EW'(MAX_GLYPHS);
    assign count_ext     = EW'(entry_count_reg);
    assign valid_entries = (count_ext < EW'(MAX_GLYPHS)) ? count_ext : EW'(MAX_GLYPHS);
    assign mid           = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign addr_ext    = PW'(s_data.data_address);
    assign addr_ok     = addr_ext < PW'(DATA_DEPTH);
    assign size_ext    = PW'(data_size_reg);
    assign lim         = (size_ext < PW'(DATA_DEPTH)) ? size_ext : PW'(DATA_DEPTH);
    assign cur_ext     = PW'(cursor_reg);
    assign ptr_inc     = ptr_reg + PW'(1);
    assign ptr_inc2    = ptr_reg + PW'(2);
    assign store_raddr = ctl.pt_start ? cur_ext : ptr_inc;

    assign wr_entry = ctl.take && (s_data.command == gsd_pkg::CMD_WRITE_ENTRY) && slot_ok;
    assign wr_byte  = ctl.take && (s_data.command == gsd_pkg::CMD_WRITE_BYTE) && addr_ok;

    assign sts.srch_open     = lo_reg < hi_reg;
    assign sts.srch_hit      = table_rd_reg[32:17] == key_reg;
    assign sts.pt_cur_bad    = cur_ext >= lim;
    assign sts.pt_move_first = !moved_reg && (store_rd_reg == gsd_pkg::BYTE_MOVE);
    assign sts.pt_next_bad   = ptr_inc >= lim;
    assign sts.pt_is_end     = store_rd_reg == gsd_pkg::BYTE_END;

    assign m_data = out_reg;

    always_ff @(posedge aclk) begin
        if (wr_entry) begin
            table_mem[slot_ext[GW-1:0]] <= {s_data.glyph_number, s_data.glyph_offset};
        end
        if (ctl.srch_probe) begin
            table_rd_reg <= table_mem[mid[GW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_byte) begin
            store_mem[addr_ext[AW-1:0]] <= s_data.data_byte;
        end
        if (ctl.pt_start || ctl.pt_eval) begin
            store_rd_reg <= store_mem[store_raddr[AW-1:0]];
        end
    end

    always_comb begin
        cursor_next = cursor_reg;
        if (ctl.srch_miss) begin
            cursor_next = gsd_pkg::CURSOR_INVALID;
        end else if (ctl.srch_step && sts.srch_hit) begin
            cursor_next = gsd_pkg::CURSOR_W'(table_rd_reg[16:0]);
        end else if (ctl.pt_eval && !sts.pt_move_first && sts.pt_is_end) begin
            cursor_next = ptr_reg[gsd_pkg::CURSOR_W-1:0];
        end else if (ctl.pt_y) begin
            cursor_next = ptr_inc2[gsd_pkg::CURSOR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            data_size_reg   <= '0;
            cursor_reg      <= gsd_pkg::CURSOR_INVALID;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    gsd_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[12:0];
                    gsd_pkg::CFG_DATA_SIZE:   data_size_reg   <= cfg_wdata;
                    default:                  ;
                endcase
            end
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            key_reg        <= s_data.glyph_number;
            lo_reg         <= '0;
            hi_reg         <= valid_entries;
            res_status_reg <= gsd_pkg::ST_ACK;
            res_x_reg      <= '0;
            res_y_reg      <= '0;
        end
        if (ctl.srch_probe) begin
            mid_reg <= mid;
        end
        if (ctl.srch_miss) begin
            res_status_reg <= gsd_pkg::ST_NOTFOUND;
        end
        if (ctl.srch_step && !sts.srch_hit) begin
            if (key_reg < table_rd_reg[32:17]) begin
                hi_reg <= mid_reg;
            end else begin
                lo_reg <= mid_reg + EW'(1);
            end
        end
        if (ctl.pt_start) begin
            ptr_reg   <= cur_ext;
            moved_reg <= 1'b0;
            if (sts.pt_cur_bad) begin
                res_status_reg <= gsd_pkg::ST_BADCUR;
            end
        end
        if (ctl.pt_eval) begin
            if (sts.pt_move_first) begin
                moved_reg <= 1'b1;
                ptr_reg   <= ptr_inc;
                if (sts.pt_next_bad) begin
                    res_status_reg <= gsd_pkg::ST_BADCUR;
                end
            end else if (sts.pt_is_end) begin
                res_status_reg <= gsd_pkg::ST_END;
            end else if (sts.pt_next_bad) begin
                res_status_reg <= gsd_pkg::ST_BADCUR;
            end else begin
                byte_x_reg <= store_rd_reg;
            end
        end
        if (ctl.pt_y) begin
            res_status_reg <= moved_reg ? gsd_pkg::ST_MOVE : gsd_pkg::ST_DRAW;
            res_x_reg      <= byte_x_reg;
            res_y_reg      <= store_rd_reg;
        end
        if (ctl.out_load) begin
            out_reg.status  <= res_status_reg;
            out_reg.point_x <= res_x_reg;
            out_reg.point_y <= res_y_reg;
            out_reg.cursor  <= cursor_reg[16:0];
        end
    end

endmodule

@@ hw/rtl/glyph_stroke_decoder_core.sv @@
// Top level of the glyph stroke decoder: sequencer plus datapath.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_data carry one command per transfer: write a glyph
//   table entry, write a stroke byte, select a glyph, or decode the next point.
//   m_valid/m_ready/m_data return exactly one result per command, in order.
//   cfg_we/cfg_index/cfg_wdata write entry_count (index 0) and data_size
//   (index 1); write them only while the block is idle.
// Sequencing
//   One command is worked on at a time. A write command goes from its transfer
//   straight to the result step. A select issues and then evaluates each probe
//   of the binary search, plus a final issue step on a miss: up to 13 probes for
//   a 4096-entry table, set by the single read port of the glyph table. A
//   next-point command's steps are set by its stroke store reads.
// Reset
//   Clears both registers and sets the cursor invalid; table and store
//   contents are undefined until written.
// Stall
//   A result waits in the output register; the next command is taken
//   meanwhile and holds in its final step until the register frees.

module glyph_stroke_decoder_core #(
    parameter int MAX_GLYPHS = 4096,
    parameter int DATA_DEPTH = 131072
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  gsd_pkg::gsd_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output gsd_pkg::gsd_out_t              m_data,
    input  logic                           cfg_we,
    input  logic [gsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    gsd_pkg::gsd_ctl_t ctl;
    gsd_pkg::gsd_sts_t sts;

    gsd_controller u_controller (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_data.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    gsd_datapath #(
        .MAX_GLYPHS (MAX_GLYPHS),
        .DATA_DEPTH (DATA_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule
